// ===== src/hcbp_pkg.sv =====
// Package for the code bit packer: field widths, command codes, code-length cap
// and the control/status structs shared by the controller and the datapath.
// Depends on nothing.
`default_nettype none

package hcbp_pkg;

  // Default alphabet size and longest code the table accepts
  localparam int NumSymbols = 128;
  localparam int MaxCodeLen = 32;

  // Field widths fixed by the interface
  localparam int CmdW   = 2;
  localparam int SymW   = 8;
  localparam int CodeW  = 32;
  localparam int LenW   = 6;
  localparam int ByteW  = 8;
  localparam int EntryW = CodeW + LenW;
  localparam int AccW   = CodeW + ByteW;

  // Stored code length saturates at the smaller of the two limits
  localparam int CodeCap = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;

  // Command codes
  localparam logic [CmdW-1:0] CmdLoad   = 2'd0;
  localparam logic [CmdW-1:0] CmdEncode = 2'd1;
  localparam logic [CmdW-1:0] CmdFlush  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // input word taken this cycle
    logic load_acc;    // load aligned code into the byte accumulator
    logic keep_short;  // code fills no byte: fold it into the pending byte
    logic emit_err;    // emit the no-code error result
    logic emit_flush;  // emit the zero-padded pending byte
    logic emit_byte;   // emit the top accumulator byte
  } hcbp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_encode;   // captured command is encode
    logic is_flush;    // captured command is flush
    logic err;         // symbol outside alphabet or not loaded
    logic pend_empty;  // no bits wait in the pending byte
    logic fits;        // pending bits plus code stay below one byte
    logic last_byte;   // accumulator holds its final whole byte
    logic out_free;    // output register can take a word this cycle
  } hcbp_stat_t;

endpackage

`default_nettype wire

// ===== src/hcbp_in_if.sv =====
// Input channel of the code bit packer: valid/ready plus the command word.
// Depends on hcbp_pkg for field widths.
`default_nettype none

interface hcbp_in_if;
  import hcbp_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [SymW-1:0] symbol;
  logic [CodeW-1:0] code_bits;
  logic [LenW-1:0] code_length;

  modport source (output valid, output command, output symbol, output code_bits,
                  output code_length, input ready);
  modport sink   (input valid, input command, input symbol, input code_bits,
                  input code_length, output ready);
endinterface

`default_nettype wire

// ===== src/hcbp_out_if.sv =====
// Output channel of the code bit packer: valid/ready plus the result word.
// Depends on hcbp_pkg for field widths.
`default_nettype none

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             status;
  logic             last_of_run;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== src/huffman_code_bit_packer.sv =====
// Code bit packer: a load writes the table on acceptance; an encode emits n
// bytes (n up to 4) after the table read and the align step, one byte per cycle
// while the output register is free. Flush and error results go from decode to
// the output register. The last result waits in an output register while the
// next word is accepted. Asynchronous active-low reset clears the loaded
// flags, pending byte and control; the table is not cleared.
`default_nettype none

module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int NUM_SYMBOLS = NumSymbols
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hcbp_in_if.sink    in_if,
  hcbp_out_if.source out_if
);

  hcbp_ctrl_t ctrl;
  hcbp_stat_t stat;

  // Sequence each word
  hcbp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_command_i (in_if.command),
    .in_ready_o   (in_if.ready),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  // Table, packer and output register
  hcbp_datapath #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (in_if.command),
    .symbol_i      (in_if.symbol),
    .code_bits_i   (in_if.code_bits),
    .code_length_i (in_if.code_length),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_byte_o    (out_if.out_byte),
    .status_o      (out_if.status),
    .last_of_run_o (out_if.last_of_run)
  );

endmodule

`default_nettype wire

// ===== src/hcbp_ctrl.sv =====
// Controller of the code bit packer: accepts words and sequences decode and
// byte emission. Depends on hcbp_pkg for command codes and the control structs.
`default_nettype none

module hcbp_ctrl
  import hcbp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [CmdW-1:0] in_command_i,
  output logic                 in_ready_o,
  input  wire hcbp_stat_t      stat_i,
  output hcbp_ctrl_t           ctrl_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDecode = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Sequence one word: decode, then drain whole bytes one per cycle while the output register is free
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.accept = accept;
    case (state_q)
      StIdle: begin
        if (accept && (in_command_i == CmdEncode || in_command_i == CmdFlush)) begin
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (stat_i.is_encode) begin
          if (stat_i.err) begin
            if (stat_i.out_free) begin
              ctrl_o.emit_err = 1'b1;
              state_d = StIdle;
            end
          end else if (stat_i.fits) begin
            ctrl_o.keep_short = 1'b1;
            state_d = StIdle;
          end else begin
            ctrl_o.load_acc = 1'b1;
            state_d = StEmit;
          end
        end else if (stat_i.is_flush && !stat_i.pend_empty) begin
          if (stat_i.out_free) begin
            ctrl_o.emit_flush = 1'b1;
            state_d = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_byte = 1'b1;
          if (stat_i.last_byte) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Encode and flush words always pass through decode
  a_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_command_i == CmdEncode || in_command_i == CmdFlush))
      |=> state_q == StDecode)
    else $error("encode or flush did not enter decode");

  // Emission only leaves when the output register can take the word
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.emit_byte || ctrl_o.emit_err || ctrl_o.emit_flush) |-> stat_i.out_free)
    else $error("result emitted into a full output register");

  // Load and ignored commands never leave idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !(in_command_i == CmdEncode || in_command_i == CmdFlush))
      |=> state_q == StIdle)
    else $error("load or unused command left idle");

endmodule

`default_nettype wire

// ===== src/hcbp_datapath.sv =====
// Datapath of the code bit packer: code table memory, loaded flags, pending
// byte, byte accumulator and output register. Depends on hcbp_pkg.
`default_nettype none

module hcbp_datapath
  import hcbp_pkg::*;
#(
  parameter int NUM_SYMBOLS = NumSymbols
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hcbp_ctrl_t       ctrl_i,
  output hcbp_stat_t            stat_o,
  input  wire logic [CmdW-1:0]  command_i,
  input  wire logic [SymW-1:0]  symbol_i,
  input  wire logic [CodeW-1:0] code_bits_i,
  input  wire logic [LenW-1:0]  code_length_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  status_o,
  output logic                  last_of_run_o
);

  localparam int IdxW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

  logic [EntryW-1:0]      mem [NUM_SYMBOLS];
  logic [EntryW-1:0]      rd_q;
  logic [NUM_SYMBOLS-1:0] loaded_q;
  logic [CmdW-1:0]        cmd_q;
  logic                   err_q;
  logic [ByteW-1:0]       pending_q;
  logic [2:0]             count_q;
  logic [AccW-1:0]        acc_q;
  logic [LenW-1:0]        total_q;
  logic                   out_valid_q;
  logic [ByteW-1:0]       out_byte_q;
  logic                   status_q;
  logic                   last_q;

  logic [IdxW-1:0]  idx;
  logic             in_range;
  logic [LenW-1:0]  len_sat;
  logic             wr_en;
  logic             rd_en;
  logic [CodeW-1:0] aligned;
  logic [AccW-1:0]  acc_new;
  logic [LenW-1:0]  total_new;
  logic             out_free;
  logic             emit_any;

  assign idx      = symbol_i[IdxW-1:0];
  assign in_range = (9'(symbol_i) < 9'(NUM_SYMBOLS));
  assign len_sat  = (code_length_i > LenW'(CodeCap)) ? LenW'(CodeCap) : code_length_i;
  assign wr_en    = ctrl_i.accept && (command_i == CmdLoad) && in_range;
  assign rd_en    = ctrl_i.accept && (command_i == CmdEncode);

  // Write a loaded entry, read the entry of an encoded symbol
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx] <= {len_sat, code_bits_i};
    end
    if (rd_en) begin
      rd_q <= mem[idx];
    end
  end

  // Track which entries hold a code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else if (wr_en) begin
      loaded_q[idx] <= 1'b1;
    end
  end

  // Capture the command and the lookup verdict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CmdLoad;
      err_q <= 1'b0;
    end else if (ctrl_i.accept) begin
      cmd_q <= command_i;
      err_q <= !(in_range && loaded_q[idx]);
    end
  end

  // Left-align the code, then place it after the pending bits
  assign aligned   = rd_q[CodeW-1:0] << (LenW'(CodeW) - rd_q[EntryW-1:CodeW]);
  assign acc_new   = {pending_q, {CodeW{1'b0}}} | ({aligned, {ByteW{1'b0}}} >> count_q);
  assign total_new = LenW'(count_q) + rd_q[EntryW-1:CodeW];

  assign out_free = !out_valid_q || out_ready_i;
  assign emit_any = ctrl_i.emit_err || ctrl_i.emit_flush || ctrl_i.emit_byte;

  // Advance the pending byte and the accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      count_q   <= '0;
      acc_q     <= '0;
      total_q   <= '0;
    end else begin
      if (ctrl_i.keep_short) begin
        pending_q <= acc_new[AccW-1:CodeW];
        count_q   <= total_new[2:0];
      end
      if (ctrl_i.load_acc) begin
        acc_q   <= acc_new;
        total_q <= total_new;
      end
      if (ctrl_i.emit_flush) begin
        pending_q <= '0;
        count_q   <= '0;
      end
      if (ctrl_i.emit_byte) begin
        acc_q   <= acc_q << ByteW;
        total_q <= total_q - LenW'(ByteW);
        if (stat_o.last_byte) begin
          pending_q <= acc_q[AccW-ByteW-1:CodeW-ByteW];
          count_q   <= total_q[2:0];
        end
      end
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_err) begin
      out_byte_q <= '0;
      status_q   <= 1'b1;
      last_q     <= 1'b1;
    end else if (ctrl_i.emit_flush) begin
      out_byte_q <= pending_q;
      status_q   <= 1'b0;
      last_q     <= 1'b1;
    end else if (ctrl_i.emit_byte) begin
      out_byte_q <= acc_q[AccW-1:CodeW];
      status_q   <= 1'b0;
      last_q     <= stat_o.last_byte;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

  // Report status to the controller
  always_comb begin
    stat_o.is_encode  = (cmd_q == CmdEncode);
    stat_o.is_flush   = (cmd_q == CmdFlush);
    stat_o.err        = err_q;
    stat_o.pend_empty = (count_q == 3'd0);
    stat_o.fits       = (total_new < LenW'(ByteW));
    stat_o.last_byte  = (total_q < LenW'(2 * ByteW));
    stat_o.out_free   = out_free;
  end

  // Pending bits below the fill level stay zero
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & (8'hFF >> count_q)) == 8'h00)
    else $error("pending byte has bits below its fill level");

  // A byte is drained only while a whole byte is in the accumulator
  a_acc_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit_byte |-> total_q >= LenW'(ByteW))
    else $error("byte emitted from a partial accumulator");

  // Error results carry a zero byte and close the run
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q) |-> (out_byte_q == 8'h00 && last_q))
    else $error("malformed error result");

endmodule

`default_nettype wire
